// File: rtl/core/cscc_pkg.sv
// ----------------------------------------------------------------------------
// cscc_pkg
// Types and constants shared by the step counter front end, queue and engine.
// ----------------------------------------------------------------------------
package cscc_pkg;

	localparam logic [31:0]  UNKNOWN_MARK = 32'hFFFF_FFFF;
	localparam logic [31:0]  LIMIT_RESET  = 32'd100000;
	// largest value whose 3n+1 still fits in 128 bits
	localparam logic [127:0] SAFE_VALUE   = 128'h5555_5555_5555_5555_5555_5555_5555_5554;
	localparam int           SHIFT_MAX    = 8;
	localparam int           COUNT_W      = 34;

	typedef enum logic {
		OP_WRITE = 1'b0,
		OP_EVAL  = 1'b1
	} op_t;

	typedef struct packed {
		op_t          op;
		logic         trivial;
		logic [15:0]  entry_index;
		logic [31:0]  entry_value;
		logic [127:0] number;
	} item_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_TEST,
		ST_LOOK,
		ST_PEAK,
		ST_SHIFT
	} eng_state_t;

endpackage

// File: rtl/core/cscc_front.sv
// ----------------------------------------------------------------------------
// cscc_front
// Takes commands, classifies them and hands them to the queue.
// ----------------------------------------------------------------------------
module cscc_front (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	output logic           busy,
	input  logic           req_type,
	input  logic [15:0]    entry_index,
	input  logic [31:0]    entry_value,
	input  logic [63:0]    number_high,
	input  logic [63:0]    number_low,
	input  logic           clearing,
	output logic           push,
	output cscc_pkg::item_t push_item,
	input  logic           q_full
);
	import cscc_pkg::*;

	logic  valid_s1;
	item_t item_s1;
	logic  take;

	assign push      = valid_s1 && !q_full;
	assign busy      = clearing || (valid_s1 && q_full);
	assign take      = start && !busy;
	assign push_item = item_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (take) begin
			valid_s1 <= 1'b1;
		end else if (push) begin
			valid_s1 <= 1'b0;
		end
	end

	// zero and one finish at once with no table lookup
	always_ff @(posedge clk) begin
		if (take) begin
			item_s1.op          <= op_t'(req_type);
			item_s1.trivial     <= (number_high == 64'd0) && (number_low[63:1] == 63'd0);
			item_s1.entry_index <= entry_index;
			item_s1.entry_value <= entry_value;
			item_s1.number      <= {number_high, number_low};
		end
	end

endmodule

// File: rtl/core/cscc_queue.sv
// ----------------------------------------------------------------------------
// cscc_queue
// Two-entry queue between the front end and the engine.
// ----------------------------------------------------------------------------
module cscc_queue (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  cscc_pkg::item_t push_item,
	output logic            full,
	input  logic            pop,
	output logic            valid,
	output cscc_pkg::item_t head
);
	import cscc_pkg::*;

	item_t      slot_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] cnt_q;

	assign full  = (cnt_q == 2'd2);
	assign valid = (cnt_q != 2'd0);
	assign head  = slot_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (push) wr_ptr_q <= ~wr_ptr_q;
			if (pop)  rd_ptr_q <= ~rd_ptr_q;
			case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 2'd1;
				2'b01:   cnt_q <= cnt_q - 2'd1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (push) slot_q[wr_ptr_q] <= push_item;
	end

endmodule

// File: rtl/core/cscc_engine.sv
// ----------------------------------------------------------------------------
// cscc_engine
// Memo store, clearing pass and the iterating Collatz datapath.
// ----------------------------------------------------------------------------
module cscc_engine #(
	parameter int TABLE_BITS = 16
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic [31:0]     step_limit,
	input  logic            q_valid,
	input  cscc_pkg::item_t head,
	output logic            pop,
	output logic            clearing,
	output logic            done,
	output logic [31:0]     step_total,
	output logic [63:0]     peak_high,
	output logic [63:0]     peak_low,
	output logic            overflow
);
	import cscc_pkg::*;

	localparam int SH_W = $clog2(SHIFT_MAX + 1);

	eng_state_t            state_q, state_d;
	logic                  clr_q;
	logic [TABLE_BITS-1:0] clr_cnt_q;
	logic [31:0]           mem_q [2**TABLE_BITS];
	logic [31:0]           rdata_q;
	logic                  mem_we;
	logic [TABLE_BITS-1:0] mem_wa;
	logic [31:0]           mem_wd;
	logic [31:0]           idx32;
	logic                  idx_ok;

	logic [127:0]          value_q;
	logic [127:0]          peak_q;
	logic [COUNT_W-1:0]    count_q;
	logic                  small_q;
	logic                  done_q;

	logic                  fin, fin_ovf, fin_add, fin_triv;
	logic                  hit, at_limit, unsafe;
	logic [SH_W-1:0]       sh_amt;
	logic [127:0]          shifted;
	logic [COUNT_W-1:0]    sum;

	function automatic logic [SH_W-1:0] ctz8(input logic [SHIFT_MAX-1:0] v);
		logic [SH_W-1:0] r;
		logic            seen;
		r    = SH_W'(SHIFT_MAX);
		seen = 1'b0;
		for (int i = 0; i < SHIFT_MAX; i++) begin
			if (v[i] && !seen) begin
				r    = SH_W'(i);
				seen = 1'b1;
			end
		end
		return r;
	endfunction

	assign clearing = clr_q;
	assign idx32    = 32'(head.entry_index);
	assign idx_ok   = (idx32 >> TABLE_BITS) == 32'd0;
	assign hit      = small_q && (rdata_q != UNKNOWN_MARK);
	assign at_limit = count_q >= COUNT_W'(step_limit);
	assign unsafe   = value_q > SAFE_VALUE;
	assign sh_amt   = ctz8(value_q[SHIFT_MAX-1:0]);
	assign shifted  = value_q >> sh_amt;
	assign sum      = count_q + (fin_add ? COUNT_W'(rdata_q) : COUNT_W'(0));

	// write port: clearing pass, then memo write commands
	always_comb begin
		if (clr_q) begin
			mem_we = 1'b1;
			mem_wa = clr_cnt_q;
			mem_wd = UNKNOWN_MARK;
		end else begin
			mem_we = (state_q == ST_IDLE) && q_valid && (head.op == OP_WRITE) && idx_ok;
			mem_wa = idx32[TABLE_BITS-1:0];
			mem_wd = head.entry_value;
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) mem_q[mem_wa] <= mem_wd;
		rdata_q <= mem_q[value_q[TABLE_BITS-1:0]];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q     <= 1'b1;
			clr_cnt_q <= '0;
		end else if (clr_q) begin
			clr_cnt_q <= clr_cnt_q + 1'b1;
			if (&clr_cnt_q) clr_q <= 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= fin;
		end
	end

	always_comb begin
		state_d  = state_q;
		pop      = 1'b0;
		fin      = 1'b0;
		fin_ovf  = 1'b0;
		fin_add  = 1'b0;
		fin_triv = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (!clr_q && q_valid) begin
					pop = 1'b1;
					if (head.op == OP_EVAL) begin
						if (head.trivial) begin
							fin      = 1'b1;
							fin_triv = 1'b1;
						end else begin
							state_d = ST_TEST;
						end
					end
				end
			end
			ST_TEST: begin
				if (value_q == 128'd1) begin
					fin     = 1'b1;
					state_d = ST_IDLE;
				end else begin
					state_d = ST_LOOK;
				end
			end
			ST_LOOK: begin
				if (hit) begin
					fin     = 1'b1;
					fin_add = 1'b1;
					state_d = ST_IDLE;
				end else if (at_limit || (value_q[0] && unsafe)) begin
					fin     = 1'b1;
					fin_ovf = 1'b1;
					state_d = ST_IDLE;
				end else if (value_q[0]) begin
					state_d = ST_PEAK;
				end else begin
					state_d = ST_SHIFT;
				end
			end
			ST_PEAK: begin
				state_d = ST_SHIFT;
			end
			ST_SHIFT: begin
				if (shifted[0]) state_d = ST_TEST;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				value_q <= head.number;
				peak_q  <= head.number;
				count_q <= '0;
			end
			ST_TEST: begin
				small_q <= (value_q >> TABLE_BITS) == 128'd0;
			end
			ST_LOOK: begin
				if (value_q[0]) begin
					value_q <= (value_q << 1) + value_q + 128'd1;
					count_q <= count_q + COUNT_W'(1);
				end
			end
			ST_PEAK: begin
				if (value_q > peak_q) peak_q <= value_q;
			end
			ST_SHIFT: begin
				value_q <= shifted;
				count_q <= count_q + COUNT_W'(sh_amt);
			end
			default: begin
				value_q <= value_q;
			end
		endcase
		if (fin) begin
			if (fin_triv) begin
				step_total <= 32'd0;
				peak_high  <= head.number[127:64];
				peak_low   <= head.number[63:0];
				overflow   <= 1'b0;
			end else begin
				step_total <= (|sum[COUNT_W-1:32]) ? 32'hFFFF_FFFF : sum[31:0];
				peak_high  <= peak_q[127:64];
				peak_low   <= peak_q[63:0];
				overflow   <= fin_ovf;
			end
		end
	end

	assign done = done_q;

	a_no_result_clearing: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> !clr_q) else $error("result during clearing pass");
	a_clear_idle: assert property (@(posedge clk) disable iff (!arst_n)
		clr_q |-> (state_q == ST_IDLE && !pop)) else $error("work during clearing pass");
	a_peak_after_odd: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_PEAK) |-> ($past(state_q) == ST_LOOK))
		else $error("peak update without odd step");
	a_count_rises: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SHIFT && $past(state_q) == ST_SHIFT) |-> (count_q >= $past(count_q)))
		else $error("step count went down");

endmodule

// File: rtl/core/collatz_step_counter_core.sv
// ----------------------------------------------------------------------------
// collatz_step_counter_core
// Collatz total stopping time of 128-bit numbers with a memo table of tails.
// ----------------------------------------------------------------------------
//
//  channel   signals                                   direction  transfer
//  command   start/busy, req_type, entry_*, number_*   in         start & !busy
//  result    done, step_total, peak_*, overflow        out        done (1 cycle)
//  config    cfg_valid/cfg_ready, cfg_data             in         valid & ready
//
// After reset the memo store is swept to the unknown marker, one entry a
// cycle: busy stays high until the sweep ends. Config is always ready.
// A memo write lands in the store once the engine takes it from the queue.
// Each loop pass of an evaluation runs a value test and a memo lookup, adds a
// peak update for an odd step and shifts trailing zeros up to 8 bits a cycle.
// Two queued commands let the front end keep taking work while the engine
// iterates; results cannot be stalled.
module collatz_step_counter_core #(
	parameter int TABLE_BITS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic        req_type,
	input  logic [15:0] entry_index,
	input  logic [31:0] entry_value,
	input  logic [63:0] number_high,
	input  logic [63:0] number_low,
	output logic        done,
	output logic [31:0] step_total,
	output logic [63:0] peak_high,
	output logic [63:0] peak_low,
	output logic        overflow,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [31:0] cfg_data
);
	import cscc_pkg::*;

	logic        clearing;
	logic        push, q_full, q_valid, pop;
	item_t       push_item, head;
	logic [31:0] limit_q;

	// step limit register
	assign cfg_ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q <= LIMIT_RESET;
		end else if (cfg_valid && cfg_ready) begin
			limit_q <= cfg_data;
		end
	end

	cscc_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.busy        (busy),
		.req_type    (req_type),
		.entry_index (entry_index),
		.entry_value (entry_value),
		.number_high (number_high),
		.number_low  (number_low),
		.clearing    (clearing),
		.push        (push),
		.push_item   (push_item),
		.q_full      (q_full)
	);

	cscc_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_item (push_item),
		.full      (q_full),
		.pop       (pop),
		.valid     (q_valid),
		.head      (head)
	);

	// engine: memo store and iteration, in command order
	cscc_engine #(
		.TABLE_BITS (TABLE_BITS)
	) u_engine (
		.clk        (clk),
		.arst_n     (arst_n),
		.step_limit (limit_q),
		.q_valid    (q_valid),
		.head       (head),
		.pop        (pop),
		.clearing   (clearing),
		.done       (done),
		.step_total (step_total),
		.peak_high  (peak_high),
		.peak_low   (peak_low),
		.overflow   (overflow)
	);

endmodule

// File: sim/collatz_step_counter_core_tb.sv
// ----------------------------------------------------------------------------
// collatz_step_counter_core_tb
// Drives memo-table writes and 128-bit start numbers into the step counter
// under several step limits. Each evaluation's expected step count, peak and
// overflow flag come from a directed row or a walker, checked in order on done.
// ----------------------------------------------------------------------------
module collatz_step_counter_core_tb;

	import cscc_pkg::*;

	localparam int MEMO_DEPTH = 1 << 16;

	typedef struct {
		logic [31:0]  steps;
		logic [127:0] peak;
		logic         ovf;
	} traj_t;

	// one directed command; has_exp marks a hand-written expectation
	typedef struct {
		op_t          op;
		logic [15:0]  idx;
		logic [31:0]  val;
		logic [127:0] num;
		logic         has_exp;
		traj_t        exp_res;
	} cmd_t;

	logic        clk;
	logic        arst_n;
	logic        start;
	logic        busy;
	logic        req_type;
	logic [15:0] entry_index;
	logic [31:0] entry_value;
	logic [63:0] number_high;
	logic [63:0] number_low;
	logic        done;
	logic [31:0] step_total;
	logic [63:0] peak_high;
	logic [63:0] peak_low;
	logic        overflow;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [31:0] cfg_data;

	// local copy of block state
	logic [31:0] memo_copy [MEMO_DEPTH];
	logic [31:0] limit_copy;

	traj_t pending_q[$];
	cmd_t  dir_rows[$];
	int    mismatches;

	collatz_step_counter_core uut (
		.clk(clk), .arst_n(arst_n),
		.start(start), .busy(busy),
		.req_type(req_type), .entry_index(entry_index), .entry_value(entry_value),
		.number_high(number_high), .number_low(number_low),
		.done(done), .step_total(step_total),
		.peak_high(peak_high), .peak_low(peak_low), .overflow(overflow),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#(200_000_000);
		$display("*** FAILED ***");
		$finish;
	end

	function automatic int trailing_zeros(logic [127:0] v);
		int k;
		k = 0;
		while (k < 128 && !v[k]) k++;
		return k;
	endfunction

	// walks the trajectory of n with the current memo contents and limit
	function automatic traj_t walk_trajectory(logic [127:0] n);
		logic [127:0] v;
		logic [127:0] t;
		longint unsigned cnt;
		int k;
		traj_t r;
		v = n;
		cnt = 0;
		r.peak = n;
		r.ovf = 1'b0;
		if (v > 128'd1) begin
			while (v != 128'd1) begin
				if (v < MEMO_DEPTH && memo_copy[v[15:0]] != UNKNOWN_MARK) begin
					cnt += memo_copy[v[15:0]];
					break;
				end
				if (cnt >= limit_copy) begin
					r.ovf = 1'b1;
					break;
				end
				if (!v[0]) begin
					k = trailing_zeros(v);
					v = v >> k;
					cnt += k;
				end else begin
					if (v > SAFE_VALUE) begin
						r.ovf = 1'b1;
						break;
					end
					t = v * 3 + 1;
					if (t > r.peak) r.peak = t;
					k = trailing_zeros(t);
					v = t >> k;
					cnt += 1 + k;
				end
			end
		end
		r.steps = (cnt > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : cnt[31:0];
		return r;
	endfunction

	// one command transfer; expectation is queued at the accepting edge
	task automatic issue(cmd_t c, int gap);
		repeat (gap) begin
			@(negedge clk);
			start <= 1'b0;
		end
		@(negedge clk);
		start       <= 1'b1;
		req_type    <= c.op;
		entry_index <= c.idx;
		entry_value <= c.val;
		number_high <= c.num[127:64];
		number_low  <= c.num[63:0];
		do @(posedge clk); while (busy);
		if (c.op == OP_WRITE) begin
			memo_copy[c.idx] = c.val;
		end else if (c.has_exp) begin
			pending_q.insert(pending_q.size(), c.exp_res);
		end else begin
			pending_q.insert(pending_q.size(), walk_trajectory(c.num));
		end
	endtask

	task automatic drain;
		@(negedge clk);
		start <= 1'b0;
		while (pending_q.size() != 0) @(posedge clk);
		// a trailing memo write yields no done; give it time to land
		repeat (20) @(posedge clk);
	endtask

	task automatic write_limit(logic [31:0] v);
		drain();
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_data  <= v;
		do @(posedge clk); while (!cfg_ready);
		limit_copy = v;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// half the time no gap, else mostly short gaps, now and then long
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 50) return 0;
		if (r < 92) return $urandom_range(1, 3);
		return $urandom_range(10, 60);
	endfunction

	// small numbers dominate so trajectories stay short and hit the memo
	function automatic logic [127:0] pick_number();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55) return $urandom_range(0, MEMO_DEPTH - 1);
		if (r < 85) return {$urandom, $urandom} >> $urandom_range(0, 40);
		if (r < 95) return {$urandom, $urandom, $urandom, $urandom};
		case ($urandom_range(0, 3))
			0: return SAFE_VALUE;
			1: return SAFE_VALUE + 1;
			2: return ~128'd0;
			default: return 128'd1 << $urandom_range(0, 127);
		endcase
	endfunction

	function automatic cmd_t pick_cmd();
		cmd_t c;
		int r;
		c.has_exp = 1'b0;
		c.exp_res = '{32'd0, 128'd0, 1'b0};
		c.num = {$urandom, $urandom, $urandom, $urandom};
		c.idx = $urandom;
		c.val = $urandom;
		if ($urandom_range(0, 99) < 30) begin
			c.op = OP_WRITE;
			if ($urandom_range(0, 9) < 7) c.idx = $urandom_range(0, 1023);
			r = $urandom_range(0, 9);
			if (r == 0) c.val = UNKNOWN_MARK;
			else if (r > 1) c.val = $urandom_range(0, 500);
		end else begin
			c.op = OP_EVAL;
			c.num = pick_number();
		end
		return c;
	endfunction

	function automatic void add_row(op_t op, logic [15:0] idx, logic [31:0] val,
			logic [127:0] num, logic has_exp, logic [31:0] steps,
			logic [127:0] peak, logic ovf);
		cmd_t c;
		c.op = op;
		c.idx = idx;
		c.val = val;
		c.num = num;
		c.has_exp = has_exp;
		c.exp_res = '{steps, peak, ovf};
		dir_rows.insert(dir_rows.size(), c);
	endfunction

	task automatic random_run(int count);
		for (int i = 0; i < count; i++) begin
			// hold off once until the engine is empty
			if (i == count / 2) drain();
			issue(pick_cmd(), pick_gap());
		end
	endtask

	// result checker; done is a one-cycle strobe that cannot be stalled
	always @(posedge clk) begin
		traj_t e;
		if (arst_n && done) begin
			if (pending_q.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result: steps=%0d peak=%h ovf=%b",
						step_total, {peak_high, peak_low}, overflow);
			end else begin
				e = pending_q.pop_front();
				if (step_total !== e.steps || peak_high !== e.peak[127:64] ||
						peak_low !== e.peak[63:0] || overflow !== e.ovf) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: exp steps=%0d peak=%h ovf=%b, got steps=%0d peak=%h ovf=%b",
							e.steps, e.peak, e.ovf, step_total,
							{peak_high, peak_low}, overflow);
				end
			end
		end
	end

	initial begin
		mismatches = 0;
		limit_copy = LIMIT_RESET;
		for (int i = 0; i < MEMO_DEPTH; i++) memo_copy[i] = UNKNOWN_MARK;
		arst_n      = 1'b0;
		start       = 1'b0;
		req_type    = OP_WRITE;
		entry_index = '0;
		entry_value = '0;
		number_high = '0;
		number_low  = '0;
		cfg_valid   = 1'b0;
		cfg_data    = '0;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// trivial numbers, powers of two, 27, the top of the range and the overflow boundary
		add_row(OP_EVAL, 0, 0, 128'd0, 1, 0, 128'd0, 0);
		add_row(OP_EVAL, 0, 0, 128'd1, 1, 0, 128'd1, 0);
		add_row(OP_EVAL, 0, 0, 128'd2, 1, 1, 128'd2, 0);
		add_row(OP_EVAL, 0, 0, ~128'd0, 1, 0, ~128'd0, 1);
		add_row(OP_EVAL, 0, 0, SAFE_VALUE + 1, 1, 0, SAFE_VALUE + 1, 1);
		add_row(OP_EVAL, 0, 0, SAFE_VALUE, 0, 0, 0, 0);
		add_row(OP_EVAL, 0, 0, 128'd1 << 64, 1, 64, 128'd1 << 64, 0);
		add_row(OP_EVAL, 0, 0, 128'd1 << 127, 1, 127, 128'd1 << 127, 0);
		add_row(OP_EVAL, 0, 0, 128'd27, 0, 0, 0, 0);
		// memo hit, unknown marker restored, top index, saturating tail
		add_row(OP_WRITE, 16'd5, 32'd7, 0, 0, 0, 0, 0);
		add_row(OP_EVAL, 0, 0, 128'd5, 1, 7, 128'd5, 0);
		add_row(OP_WRITE, 16'd5, 32'hFFFF_FFFE, 0, 0, 0, 0, 0);
		add_row(OP_EVAL, 0, 0, 128'd3, 1, 32'hFFFF_FFFF, 128'd10, 0);
		add_row(OP_WRITE, 16'd5, UNKNOWN_MARK, 0, 0, 0, 0, 0);
		add_row(OP_EVAL, 0, 0, 128'd5, 0, 0, 0, 0);
		add_row(OP_WRITE, 16'hFFFF, 32'd0, 0, 0, 0, 0, 0);
		add_row(OP_EVAL, 0, 0, 128'hFFFF, 1, 0, 128'hFFFF, 0);
		add_row(OP_WRITE, 16'd0, 32'hFFFF_FFFF, 0, 0, 0, 0, 0);
		add_row(OP_EVAL, 0, 0, {64'hFFFF_FFFF_FFFF_FFFF, 64'h0}, 0, 0, 0, 0);
		add_row(OP_EVAL, 0, 0, {64'h0, 64'hFFFF_FFFF_FFFF_FFFF}, 0, 0, 0, 0);
		foreach (dir_rows[i]) issue(dir_rows[i], pick_gap());

		random_run(150);
		write_limit(32'd0);
		// limit zero aborts at once; entry 6 is made unknown so the memo cannot answer
		add_row(OP_WRITE, 16'd6, UNKNOWN_MARK, 0, 0, 0, 0, 0);
		add_row(OP_EVAL, 0, 0, 128'd6, 1, 0, 128'd6, 1);
		issue(dir_rows[dir_rows.size() - 2], 0);
		issue(dir_rows[dir_rows.size() - 1], 0);
		random_run(60);
		write_limit(32'hFFFF_FFFF);
		random_run(120);
		write_limit(32'd40);
		random_run(60);
		write_limit(LIMIT_RESET);
		random_run(60);

		@(negedge clk);
		start <= 1'b0;
		while (pending_q.size() != 0) @(posedge clk);
		repeat (50) @(posedge clk);
		if (mismatches == 0 && pending_q.size() == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule

// File: collatz_step_counter_core.f
rtl/core/cscc_pkg.sv
rtl/core/cscc_front.sv
rtl/core/cscc_queue.sv
rtl/core/cscc_engine.sv
rtl/core/collatz_step_counter_core.sv
sim/collatz_step_counter_core_tb.sv
